FILE: rtl/core/open_address_hash_table_assert.svh
// Assertion macros for the open-address hash table.
// Expect clk and rst_n in the scope of use; no other dependencies.
`ifndef OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define OAHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("open_address_hash_table: implication check failed");

// next-cycle implication
`define OAHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("open_address_hash_table: next-cycle check failed");

`endif

FILE: rtl/core/oaht_pkg.sv
// Shared types and constants of the open-address hash table.
// No dependencies.
package oaht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int CNT_W       = $clog2(KEY_WIDTH);
    localparam int SLOT_W      = 6;
    localparam int COLL_W      = 7;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(15);

    typedef struct packed {
        logic [1:0]           action;
        logic [KEY_WIDTH-1:0] key;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              stored;
        logic [COLL_W-1:0] collisions;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [KEY_WIDTH-1:0] wr_data;
        logic                 clr;
    } store_req_t;

endpackage

FILE: rtl/core/oaht_hash.sv
// Home-slot unit: key modulo table size, one quotient bit per cycle.
// Depends on oaht_pkg.
module oaht_hash (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [oaht_pkg::KEY_WIDTH-1:0] key,
    input  logic [oaht_pkg::SIZE_W-1:0]    size,
    output logic                           done,
    output logic [oaht_pkg::ADDR_W-1:0]    rem
);
    import oaht_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]    trial;

    // remainder stays below size, so it fits in ADDR_W bits before the shift
    assign trial = {rem_reg, key_reg[KEY_WIDTH-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        size_next = size_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            key_next  = key;
            size_next = size;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            key_next = {key_reg[KEY_WIDTH-2:0], 1'b0};
            rem_next = (trial >= size_reg) ? ADDR_W'(trial - size_reg) : trial[ADDR_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(KEY_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        size_reg <= size_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/core/oaht_store.sv
// Slot store: synchronous key memory plus per-slot valid bits.
// Depends on oaht_pkg. Invalid slots read as empty (zero).
module oaht_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  oaht_pkg::store_req_t           req,
    output logic [oaht_pkg::KEY_WIDTH-1:0] rd_data
);
    import oaht_pkg::*;

    logic [KEY_WIDTH-1:0]   mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [KEY_WIDTH-1:0]   q_reg;
    logic                   q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        q_reg <= mem[req.rd_addr];
    end

    // valid bits: a clear drops them all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            q_vld_reg <= valid_reg[req.rd_addr];
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = q_vld_reg ? q_reg : '0;

endmodule

FILE: rtl/core/open_address_hash_table.sv
// Top level of the open-address hash table: sequencer, probe stepping, result register.
// Depends on oaht_pkg, oaht_hash, oaht_store, open_address_hash_table_assert.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------
//  request | req_valid / req_ready | req_data  (action, key)
//  result  | rsp_valid / rsp_ready | rsp_data  (found, slot, stored, collisions)
//  config  | cfg_we                | cfg_index, cfg_data
//
// Insert/search: the bit-serial remainder unit first finds the home slot, then one
// probe per cycle goes through the slot memory, whose read data is registered.
// Clear and the unused action go straight to the finish state; clear drops all valid bits at once.
// After reset every slot reads empty; no clearing pass is needed.
// A request is taken whenever the sequencer is idle, even while a result waits;
// a finished result waits in the sequencer until the result register is free.
module open_address_hash_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  oaht_pkg::req_t                 req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output oaht_pkg::rsp_t                 rsp_data,
    input  logic                           cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [oaht_pkg::CFG_W-1:0]     cfg_data
);
    import oaht_pkg::*;

`include "open_address_hash_table_assert.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_HASH   = 2'd1;
    localparam logic [1:0] ST_PROBE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // a + b modulo m, both operands already below m
    function automatic logic [SIZE_W-1:0] mod_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b,
                                                  input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] s;
        logic [SIZE_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[SIZE_W-1:0] : s[SIZE_W-1:0];
    endfunction

    // configuration registers
    logic [SIZE_W-1:0] cfg_size_reg;
    logic              cfg_mode_reg;
    logic [SIZE_W-1:0] size_use;

    // sequencer and probe state
    logic [1:0]           state_reg, state_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 search_reg, search_next;
    logic                 mode_reg, mode_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [SIZE_W-1:0]    pos_reg, pos_next;     // slot being issued
    logic [SIZE_W-1:0]    d_reg, d_next;         // probe number being issued
    logic [SIZE_W-1:0]    sq_reg, sq_next;       // d*d mod size
    logic [SIZE_W-1:0]    term_reg, term_next;   // (2d+1) mod size
    logic [ADDR_W-1:0]    chk_pos_reg, chk_pos_next;
    logic [SIZE_W-1:0]    chk_d_reg, chk_d_next;
    rsp_t                 res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_data_reg, rsp_data_next;

    logic                 req_fire;
    logic                 hash_start;
    logic                 hash_done;
    logic [ADDR_W-1:0]    hash_rem;
    store_req_t           st_req;
    logic [KEY_WIDTH-1:0] st_rd_data;
    logic                 hit;
    logic                 last;
    logic [SIZE_W-1:0]    step;
    logic [SIZE_W-1:0]    three_mod;
    logic                 rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_size_reg <= SIZE_RESET;
            cfg_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TABLE_SIZE: cfg_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_PROBE_MODE: cfg_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // size 0 behaves as 1, anything above the depth as the full depth
    always_comb
    begin
        if (cfg_size_reg == '0)
        begin
            size_use = SIZE_W'(1);
        end
        else if (cfg_size_reg > SIZE_W'(TABLE_DEPTH))
        begin
            size_use = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size_use = cfg_size_reg;
        end
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign hash_start = req_fire &&
                        (req_data.action == ACT_INSERT || req_data.action == ACT_SEARCH);

    oaht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req_data.key),
        .size  (size_use),
        .done  (hash_done),
        .rem   (hash_rem)
    );

    oaht_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (st_req),
        .rd_data (st_rd_data)
    );

    // check stage: data for chk_pos_reg is on st_rd_data this cycle
    assign hit  = search_reg ? (st_rd_data == key_reg) : (st_rd_data == '0);
    assign last = (chk_d_reg >= size_reg);
    assign step = mode_reg ? sq_reg : SIZE_W'(1);
    // 3 mod size, only used for sizes of two and up
    assign three_mod = (SIZE_W'(3) >= size_use) ? SIZE_W'(3) - size_use : SIZE_W'(3);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        chk_valid_next = 1'b0;
        key_next       = key_reg;
        search_next    = search_reg;
        mode_next      = mode_reg;
        size_next      = size_reg;
        pos_next       = pos_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        term_next      = term_reg;
        chk_pos_next   = pos_reg[ADDR_W-1:0];
        chk_d_next     = d_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;

        st_req.rd_addr = pos_reg[ADDR_W-1:0];
        st_req.wr_en   = 1'b0;
        st_req.wr_addr = chk_pos_reg;
        st_req.wr_data = key_reg;
        st_req.clr     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    key_next    = req_data.key;
                    search_next = (req_data.action == ACT_SEARCH);
                    mode_next   = cfg_mode_reg;
                    size_next   = size_use;
                    res_next    = '0;
                    sq_next     = (size_use == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                    term_next   = three_mod;
                    if (hash_start)
                    begin
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        // clear, or the unused code: all-zero result
                        st_req.clr = (req_data.action == ACT_CLEAR);
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    pos_next   = {1'b0, hash_rem};
                    d_next     = SIZE_W'(1);
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // issue the next slot every cycle; reads past the end are dropped
                chk_valid_next = 1'b1;
                pos_next       = mod_add(pos_reg, step, size_reg);
                sq_next        = mod_add(sq_reg, term_reg, size_reg);
                term_next      = mod_add(term_reg, SIZE_W'(2), size_reg);
                d_next         = d_reg + SIZE_W'(1);
                if (chk_valid_reg && (hit || last))
                begin
                    chk_valid_next = 1'b0;
                    state_next     = ST_FINISH;
                    res_next.found  = search_reg && hit;
                    res_next.stored = !search_reg && hit;
                    res_next.slot   = hit ? SLOT_W'(chk_pos_reg) : '0;
                    if (search_reg)
                    begin
                        res_next.collisions = '0;
                    end
                    else
                    begin
                        res_next.collisions = hit ? COLL_W'(chk_d_reg - SIZE_W'(1))
                                                  : COLL_W'(chk_d_reg);
                    end
                    st_req.wr_en = !search_reg && hit;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        search_reg   <= search_next;
        mode_reg     <= mode_next;
        size_reg     <= size_next;
        pos_reg      <= pos_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        term_reg     <= term_next;
        chk_pos_reg  <= chk_pos_next;
        chk_d_reg    <= chk_d_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // checked probes stay inside the table and within the probe limit
    `OAHT_ASSERT_IMP(a_chk_in_range, state_reg == ST_PROBE && chk_valid_reg,
        (SIZE_W'(chk_pos_reg) < size_reg) && (chk_d_reg <= size_reg))
    `OAHT_ASSERT_NXT(a_hash_to_probe, state_reg == ST_HASH && hash_done,
        state_reg == ST_PROBE)
    `OAHT_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg) == ST_FINISH)
    `OAHT_ASSERT_IMP(a_found_xor_stored, rsp_valid_reg,
        !(rsp_data_reg.found && rsp_data_reg.stored))

endmodule
